/* hw/rtl/cau_pkg.sv */
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_INC = 3'd5,
        OP_DEC = 3'd6,
        OP_CMP = 3'd7
    } t_op;

    // Quotient bits produced by the divider, and the remainder width that
    // holds a numerator shifted by up to 32 fractional bits.
    localparam int QUO_BITS = 32;
    localparam int REM_BITS = 64 + QUO_BITS;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_equal;
        logic               div_zero;
        logic               overflowed;
    } t_result;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    // Work item as it travels down the divider stages.
    typedef struct packed {
        logic                valid;
        logic                is_div;
        t_result             res;
        logic                neg_re;
        logic                neg_im;
        logic                big_re;
        logic                big_im;
        logic [REM_BITS-1:0] rem_re;
        logic [REM_BITS-1:0] rem_im;
        logic [QUO_BITS-1:0] q_re;
        logic [QUO_BITS-1:0] q_im;
        logic [63:0]         den;
    } t_pipe;

    function automatic logic [65:0] abs66(input logic signed [65:0] x);
        logic [65:0] r;
        begin
            r = x[65] ? 66'(-x) : 66'(x);
            return r;
        end
    endfunction

    // Saturate a sign-magnitude value to 32-bit two's complement.
    function automatic t_sat sat_sm(input logic neg, input logic [65:0] mag);
        t_sat r;
        begin
            r.ovf = 1'b0;
            if (neg) begin
                if (mag > 66'h0_8000_0000) begin
                    r.val = 32'h8000_0000;
                    r.ovf = 1'b1;
                end else begin
                    r.val = ~mag[31:0] + 32'd1;
                end
            end else begin
                if (mag > 66'h0_7FFF_FFFF) begin
                    r.val = 32'h7FFF_FFFF;
                    r.ovf = 1'b1;
                end else begin
                    r.val = mag[31:0];
                end
            end
            return r;
        end
    endfunction

    function automatic t_sat sat_s66(input logic signed [65:0] x);
        return sat_sm(x[65], abs66(x));
    endfunction

endpackage

/* hw/rtl/cau_front.sv */
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cau_pkg::t_cmd  i_cmd,
    output cau_pkg::t_pipe o_pipe
);

    // Stage 1: operand register
    logic          r_v1;
    cau_pkg::t_cmd r_c1;

    // Stage 2: products and simple-op results
    logic                 r_v2;
    cau_pkg::t_op         r_op2;
    logic signed [63:0]   r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_br2, r_p_bi2;
    cau_pkg::t_result     r_res2;
    cau_pkg::t_result     n_res2;

    // Stage 3: sums of products
    logic             r_v3;
    logic             r_div3;
    cau_pkg::t_result r_res3;
    cau_pkg::t_result n_res3;
    logic             r_nre3, r_nim3;
    logic [65:0]      r_mre3, r_mim3;
    logic [63:0]      r_den3;

    logic signed [65:0] w_mul_re, w_mul_im, w_num_re, w_num_im, w_s_re, w_s_im;
    logic signed [65:0] w_one;
    cau_pkg::t_sat      w_sr, w_si;
    logic [cau_pkg::REM_BITS-1:0] w_n_re, w_n_im, w_dtop;

    assign w_one = 66'sd1 <<< FRAC_BITS;

    always_comb begin
        w_s_re = '0;
        w_s_im = '0;
        case (r_c1.op)
            cau_pkg::OP_ADD: begin
                w_s_re = 66'(r_c1.a_re) + 66'(r_c1.b_re);
                w_s_im = 66'(r_c1.a_im) + 66'(r_c1.b_im);
            end
            cau_pkg::OP_SUB: begin
                w_s_re = 66'(r_c1.a_re) - 66'(r_c1.b_re);
                w_s_im = 66'(r_c1.a_im) - 66'(r_c1.b_im);
            end
            cau_pkg::OP_NEG: begin
                w_s_re = -66'(r_c1.a_re);
                w_s_im = -66'(r_c1.a_im);
            end
            cau_pkg::OP_INC: begin
                w_s_re = 66'(r_c1.a_re) + w_one;
                w_s_im = 66'(r_c1.a_im);
            end
            cau_pkg::OP_DEC: begin
                w_s_re = 66'(r_c1.a_re) - w_one;
                w_s_im = 66'(r_c1.a_im);
            end
            default: begin
                w_s_re = '0;
                w_s_im = '0;
            end
        endcase
        w_sr = cau_pkg::sat_s66(w_s_re);
        w_si = cau_pkg::sat_s66(w_s_im);
        n_res2            = '0;
        n_res2.res_re     = w_sr.val;
        n_res2.res_im     = w_si.val;
        n_res2.overflowed = w_sr.ovf | w_si.ovf;
        n_res2.is_equal   = (r_c1.op == cau_pkg::OP_CMP) &&
                            (r_c1.a_re == r_c1.b_re) && (r_c1.a_im == r_c1.b_im);
    end

    // Mul parts go through sign-magnitude so the shift truncates toward zero.
    cau_pkg::t_sat w_mr, w_mi;
    always_comb begin
        w_mul_re = 66'(r_p_rr) - 66'(r_p_ii);
        w_mul_im = 66'(r_p_ri) + 66'(r_p_ir);
        w_num_re = 66'(r_p_rr) + 66'(r_p_ii);
        w_num_im = 66'(r_p_ir) - 66'(r_p_ri);
        w_mr = cau_pkg::sat_sm(w_mul_re[65], cau_pkg::abs66(w_mul_re) >> FRAC_BITS);
        w_mi = cau_pkg::sat_sm(w_mul_im[65], cau_pkg::abs66(w_mul_im) >> FRAC_BITS);
        n_res3 = r_res2;
        if (r_op2 == cau_pkg::OP_MUL) begin
            n_res3.res_re     = w_mr.val;
            n_res3.res_im     = w_mi.val;
            n_res3.overflowed = w_mr.ovf | w_mi.ovf;
        end
    end

    assign w_n_re = cau_pkg::REM_BITS'(r_mre3[63:0]) << FRAC_BITS;
    assign w_n_im = cau_pkg::REM_BITS'(r_mim3[63:0]) << FRAC_BITS;
    assign w_dtop = cau_pkg::REM_BITS'(r_den3) << cau_pkg::QUO_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1    <= i_cmd;
        r_op2   <= r_c1.op;
        r_p_rr  <= r_c1.a_re * r_c1.b_re;
        r_p_ii  <= r_c1.a_im * r_c1.b_im;
        r_p_ri  <= r_c1.a_re * r_c1.b_im;
        r_p_ir  <= r_c1.a_im * r_c1.b_re;
        r_p_br2 <= r_c1.b_re * r_c1.b_re;
        r_p_bi2 <= r_c1.b_im * r_c1.b_im;
        r_res2  <= n_res2;
        r_div3  <= (r_op2 == cau_pkg::OP_DIV);
        r_res3  <= n_res3;
        r_nre3  <= w_num_re[65];
        r_nim3  <= w_num_im[65];
        r_mre3  <= cau_pkg::abs66(w_num_re);
        r_mim3  <= cau_pkg::abs66(w_num_im);
        r_den3  <= 64'(r_p_br2) + 64'(r_p_bi2);
        // Stage 4: align numerators, flag quotients past 32 bits
        if (!i_rst_n) begin
            o_pipe.valid <= 1'b0;
        end else begin
            o_pipe.valid <= r_v3;
        end
        o_pipe.is_div <= r_div3;
        o_pipe.res    <= r_res3;
        o_pipe.neg_re <= r_nre3;
        o_pipe.neg_im <= r_nim3;
        o_pipe.big_re <= (w_n_re >= w_dtop);
        o_pipe.big_im <= (w_n_im >= w_dtop);
        o_pipe.rem_re <= w_n_re;
        o_pipe.rem_im <= w_n_im;
        o_pipe.q_re   <= '0;
        o_pipe.q_im   <= '0;
        o_pipe.den    <= r_den3;
    end

endmodule

/* hw/rtl/cau_div_stage.sv */
module cau_div_stage #(
    parameter int BIT = 31
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cau_pkg::t_pipe i_pipe,
    output cau_pkg::t_pipe o_pipe
);

    logic [cau_pkg::REM_BITS-1:0] w_dk;
    logic                         w_ge_re, w_ge_im;
    cau_pkg::t_pipe               n_pipe;

    assign w_dk    = cau_pkg::REM_BITS'(i_pipe.den) << BIT;
    assign w_ge_re = i_pipe.rem_re >= w_dk;
    assign w_ge_im = i_pipe.rem_im >= w_dk;

    // Restoring step: one quotient bit per lane.
    always_comb begin
        n_pipe = i_pipe;
        if (w_ge_re) begin
            n_pipe.rem_re    = i_pipe.rem_re - w_dk;
            n_pipe.q_re[BIT] = 1'b1;
        end
        if (w_ge_im) begin
            n_pipe.rem_im    = i_pipe.rem_im - w_dk;
            n_pipe.q_im[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pipe.valid <= 1'b0;
        end else begin
            o_pipe.valid <= i_pipe.valid;
        end
        o_pipe.is_div <= n_pipe.is_div;
        o_pipe.res    <= n_pipe.res;
        o_pipe.neg_re <= n_pipe.neg_re;
        o_pipe.neg_im <= n_pipe.neg_im;
        o_pipe.big_re <= n_pipe.big_re;
        o_pipe.big_im <= n_pipe.big_im;
        o_pipe.rem_re <= n_pipe.rem_re;
        o_pipe.rem_im <= n_pipe.rem_im;
        o_pipe.q_re   <= n_pipe.q_re;
        o_pipe.q_im   <= n_pipe.q_im;
        o_pipe.den    <= n_pipe.den;
    end

endmodule

/* hw/rtl/cau_out.sv */
module cau_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cau_pkg::t_pipe   i_pipe,
    output logic             o_done,
    output cau_pkg::t_result o_result
);

    logic [65:0]      w_mag_re, w_mag_im;
    cau_pkg::t_sat    w_sr, w_si;
    cau_pkg::t_result n_result;

    // A quotient past 32 bits only needs to read as out of range.
    assign w_mag_re = i_pipe.big_re ? 66'h1_0000_0000 : 66'(i_pipe.q_re);
    assign w_mag_im = i_pipe.big_im ? 66'h1_0000_0000 : 66'(i_pipe.q_im);
    assign w_sr     = cau_pkg::sat_sm(i_pipe.neg_re, w_mag_re);
    assign w_si     = cau_pkg::sat_sm(i_pipe.neg_im, w_mag_im);

    always_comb begin
        n_result = i_pipe.res;
        if (i_pipe.is_div) begin
            n_result = '0;
            if (i_pipe.den == 64'd0) begin
                n_result.div_zero = 1'b1;
            end else begin
                n_result.res_re     = w_sr.val;
                n_result.res_im     = w_si.val;
                n_result.overflowed = w_sr.ovf | w_si.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// Complex-number ALU, signed fixed point with FRAC_BITS fractional bits.
//
// Command channel: drive i_cmd (op, a, b) and raise start; the command
// transfer happens at the rising edge where start is high and busy is low.
// busy stays low: the pipeline takes a new command every cycle.
// Result channel: o_done is high for exactly one cycle with o_result; the
// receiver cannot hold it off, so it must take it in that cycle.
// Every op passes through the same registered stages in order: operand
// register, product stage (six 32x32 multipliers), sum stage, numerator
// alignment, then 32 restoring divider stages (one quotient bit each, real
// and imaginary lanes side by side), then the saturation stage. Non-divide
// ops ride the same stages unchanged, so results leave in command order.
// Throughput: one result per cycle.
// Reset (synchronous, i_rst_n low) clears every stage valid bit; commands in
// flight are dropped and no o_done follows them.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cau_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output cau_pkg::t_result o_result
);

    localparam int LATENCY = 5 + cau_pkg::QUO_BITS;

    cau_pkg::t_pipe w_pipe [cau_pkg::QUO_BITS+1];

    // Never stall the command side.
    assign busy = 1'b0;

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_cmd   (i_cmd),
        .o_pipe  (w_pipe[0])
    );

    // Divider chain: most significant quotient bit first.
    for (genvar g = 0; g < cau_pkg::QUO_BITS; g++) begin : g_div
        cau_div_stage #(
            .BIT(cau_pkg::QUO_BITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pipe  (w_pipe[g]),
            .o_pipe  (w_pipe[g+1])
        );
    end

    cau_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pipe   (w_pipe[cau_pkg::QUO_BITS]),
        .o_done   (o_done),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("command transfer not followed by result strobe");

    a_strobe_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_pipe[cau_pkg::QUO_BITS].valid))
        else $error("result strobe without an item in the last divider stage");

    a_dz_no_ovf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.div_zero) |->
            (!o_result.overflowed && !o_result.is_equal &&
             o_result.res_re == 32'sd0 && o_result.res_im == 32'sd0))
        else $error("divide-by-zero result not clean");

    a_eq_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.is_equal) |->
            (!o_result.overflowed && !o_result.div_zero))
        else $error("compare result carries arithmetic flags");
`endif

endmodule
